@@ sv/frx_pkg.sv @@
// Package for the length/checksum frame receiver.
// Holds operation, phase and error codes and the result record type.
// No dependencies.
`default_nettype none

package frx_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_LENGTH   = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT  = 2'd2;
  localparam logic [1:0] ERR_CHECKSUM = 2'd3;

  localparam logic [1:0] REG_DONE_CODE  = 2'd0;
  localparam logic [1:0] REG_ABORT_CODE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT    = 2'd2;
  localparam logic [1:0] REG_MAX_LEN    = 2'd3;

  localparam logic [7:0] DONE_CODE_RST  = 8'd1;
  localparam logic [7:0] ABORT_CODE_RST = 8'd4;
  localparam logic [7:0] TIMEOUT_RST    = 8'd100;
  localparam logic [7:0] MAX_LEN_RST    = 8'd255;
  localparam logic [7:0] TICK_SAT       = 8'hFF;

  typedef struct packed {
    logic [7:0] done_code;
    logic [7:0] abort_code;
    logic [7:0] timeout_ticks;
    logic [7:0] max_packet_length;
  } frx_cfg_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       finished;
    logic       success;
    logic [1:0] error_kind;
    logic       busy_res;
  } frx_result_t;

endpackage

`default_nettype wire

@@ sv/frx_core.sv @@
// Frame receive state machine: phase, byte count, running checksum,
// write position and idle tick counter. Produces one result per item.
// Depends on frx_pkg.
`default_nettype none

module frx_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire logic [1:0]          operation,
  input  wire logic [7:0]          data_byte,
  input  wire frx_pkg::frx_cfg_t   cfg,
  output frx_pkg::frx_result_t     result
);

  frx_pkg::phase_t phase, phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] write_position, write_position_next;
  logic [7:0] idle_ticks, idle_ticks_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= frx_pkg::PH_IDLE;
      bytes_left     <= '0;
      running_sum    <= '0;
      write_position <= '0;
      idle_ticks     <= '0;
    end else if (push) begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      running_sum    <= running_sum_next;
      write_position <= write_position_next;
      idle_ticks     <= idle_ticks_next;
    end
  end

  always_comb begin
    logic       end_txn;
    logic       ok;
    logic [1:0] err;
    end_txn             = 1'b0;
    ok                  = 1'b0;
    err                 = frx_pkg::ERR_NONE;
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    running_sum_next    = running_sum;
    write_position_next = write_position;
    idle_ticks_next     = idle_ticks;
    result              = '0;

    case (frx_pkg::op_t'(operation))
      frx_pkg::OP_START: begin
        result.tx_valid     = 1'b1;
        result.tx_byte      = data_byte;
        phase_next          = frx_pkg::PH_LEN;
        bytes_left_next     = '0;
        running_sum_next    = '0;
        write_position_next = '0;
        idle_ticks_next     = '0;
      end
      frx_pkg::OP_BYTE: begin
        if (phase == frx_pkg::PH_LEN) begin
          if (data_byte == 8'd0 || data_byte > cfg.max_packet_length) begin
            end_txn = 1'b1;
            err     = frx_pkg::ERR_LENGTH;
          end else begin
            running_sum_next = data_byte;
            bytes_left_next  = data_byte - 8'd1;
            idle_ticks_next  = '0;
            phase_next       = frx_pkg::PH_BODY;
            // length one: frame ends here, sum is the length itself
            if (bytes_left_next == 8'd0) begin
              end_txn = 1'b1;
              ok      = (running_sum_next == 8'd0);
              err     = ok ? frx_pkg::ERR_NONE : frx_pkg::ERR_CHECKSUM;
            end
          end
        end else if (phase == frx_pkg::PH_BODY) begin
          running_sum_next    = running_sum + data_byte;
          result.store_valid  = 1'b1;
          result.store_index  = write_position;
          result.store_byte   = data_byte;
          write_position_next = write_position + 8'd1;
          bytes_left_next     = bytes_left - 8'd1;
          idle_ticks_next     = '0;
          if (bytes_left_next == 8'd0) begin
            end_txn = 1'b1;
            ok      = (running_sum_next == 8'd0);
            err     = ok ? frx_pkg::ERR_NONE : frx_pkg::ERR_CHECKSUM;
          end
        end
      end
      frx_pkg::OP_TICK: begin
        if (phase != frx_pkg::PH_IDLE) begin
          // saturate the tick count
          if (idle_ticks != frx_pkg::TICK_SAT) begin
            idle_ticks_next = idle_ticks + 8'd1;
          end
          if (idle_ticks_next >= cfg.timeout_ticks) begin
            end_txn = 1'b1;
            err     = frx_pkg::ERR_TIMEOUT;
          end
        end
      end
      default: begin
      end
    endcase

    if (end_txn) begin
      result.tx_valid   = 1'b1;
      result.tx_byte    = ok ? cfg.done_code : cfg.abort_code;
      result.finished   = 1'b1;
      result.success    = ok;
      result.error_kind = err;
      phase_next        = frx_pkg::PH_IDLE;
    end
    result.busy_res = (phase_next != frx_pkg::PH_IDLE);
  end

endmodule

`default_nettype wire

@@ sv/frx_outbuf.sv @@
// Two-entry result buffer: output register plus skid register, so an item
// can be taken while a finished result waits downstream.
// Depends on frx_pkg.
`default_nettype none

module frx_outbuf (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire frx_pkg::frx_result_t  push_data,
  output logic                       space,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output frx_pkg::frx_result_t       out_data
);

  logic                 main_valid;
  logic                 skid_valid;
  frx_pkg::frx_result_t main_data;
  frx_pkg::frx_result_t skid_data;

  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      // output slot frees: refill from skid first, then from the new item
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || out_ready) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ sv/length_checksum_frame_receiver_top.sv @@
// Top level of the length/checksum frame receiver: configuration registers,
// receive state machine and result buffer. Depends on frx_pkg, frx_core,
// frx_outbuf.
// Each result is registered in the output or skid register on acceptance.
// Throughput: one item per cycle while the skid register is empty; the state
// update is a single 8-bit add and compare. The skid keeps input open in a stall.
// Reset: synchronous; clears phase and counters, loads register defaults.
`default_nettype none

module length_checksum_frame_receiver_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            tx_valid,
  output logic [7:0]      tx_byte,
  output logic            store_valid,
  output logic [7:0]      store_index,
  output logic [7:0]      store_byte,
  output logic            finished,
  output logic            success,
  output logic [1:0]      error_kind,
  output logic            busy_res,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  frx_pkg::frx_cfg_t    cfg;
  frx_pkg::frx_result_t core_result;
  frx_pkg::frx_result_t out_data;
  logic                 push;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.done_code         <= frx_pkg::DONE_CODE_RST;
      cfg.abort_code        <= frx_pkg::ABORT_CODE_RST;
      cfg.timeout_ticks     <= frx_pkg::TIMEOUT_RST;
      cfg.max_packet_length <= frx_pkg::MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        frx_pkg::REG_DONE_CODE:  cfg.done_code         <= cfg_data;
        frx_pkg::REG_ABORT_CODE: cfg.abort_code        <= cfg_data;
        frx_pkg::REG_TIMEOUT:    cfg.timeout_ticks     <= cfg_data;
        frx_pkg::REG_MAX_LEN:    cfg.max_packet_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign push = in_valid && in_ready;

  frx_core u_core (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .operation (operation),
    .data_byte (data_byte),
    .cfg       (cfg),
    .result    (core_result)
  );

  frx_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (core_result),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign tx_valid    = out_data.tx_valid;
  assign tx_byte     = out_data.tx_byte;
  assign store_valid = out_data.store_valid;
  assign store_index = out_data.store_index;
  assign store_byte  = out_data.store_byte;
  assign finished    = out_data.finished;
  assign success     = out_data.success;
  assign error_kind  = out_data.error_kind;
  assign busy_res    = out_data.busy_res;

endmodule

`default_nettype wire
